// File: sv/mcu_alu_execute_with_flags_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the execute block.
// ----------------------------------------------------------------------------
`ifndef MCU_ALU_EXECUTE_WITH_FLAGS_TOP_MACROS_SVH
`define MCU_ALU_EXECUTE_WITH_FLAGS_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MCUAEF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define MCUAEF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: sv/mcuaef_pkg.sv
// ----------------------------------------------------------------------------
// mcuaef_pkg
// Types, codes and helper functions for the ALU execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcuaef_pkg;

   localparam int PC_BITS_DEF = 16;
   localparam int REG_COUNT   = 32;
   localparam int BANK_DEPTH  = REG_COUNT / 2;
   localparam int DELTA_BITS  = 14;

   typedef enum logic [4:0] {
      K_ADD    = 5'd0,
      K_ADC    = 5'd1,
      K_SUB    = 5'd2,
      K_SUBI   = 5'd3,
      K_SBC    = 5'd4,
      K_SBCI   = 5'd5,
      K_ADIW   = 5'd6,
      K_SBIW   = 5'd7,
      K_AND    = 5'd8,
      K_ANDI   = 5'd9,
      K_OR     = 5'd10,
      K_ORI    = 5'd11,
      K_EOR    = 5'd12,
      K_COM    = 5'd13,
      K_NEG    = 5'd14,
      K_INC    = 5'd15,
      K_DEC    = 5'd16,
      K_CP     = 5'd17,
      K_CPC    = 5'd18,
      K_CPI    = 5'd19,
      K_MUL    = 5'd20,
      K_MULS   = 5'd21,
      K_MULSU  = 5'd22,
      K_FMUL   = 5'd23,
      K_FMULS  = 5'd24,
      K_LDI    = 5'd25,
      K_RJMP   = 5'd26,
      K_BRANCH = 5'd27,
      K_FMULSU = 5'd28,
      K_OTHER  = 5'd29
   } kind_type;

   typedef struct packed {
      logic [4:0] a;
      logic [4:0] b;
   } rd_pair_type;

   typedef struct packed {
      logic [7:0]            flags;
      logic [4:0]            idx;
      logic [7:0]            lo;
      logic [7:0]            hi;
      logic                  wl;
      logic                  wh;
      logic                  taken;
      logic                  lng;
      logic [DELTA_BITS-1:0] delta;
   } exec_res_type;

   function automatic rd_pair_type rd_addr(input logic [4:0] kind, input logic [15:0] w);
      rd_pair_type r;
      r = '0;
      case (kind_type'(kind)) inside
         K_ADD, K_ADC, K_SUB, K_SBC, K_CP, K_CPC, K_AND, K_OR, K_EOR, K_MUL: begin
            r.a = w[8:4];
            r.b = {w[9], w[3:0]};
         end
         K_COM, K_NEG, K_INC, K_DEC: begin
            r.a = w[8:4];
         end
         K_SUBI, K_SBCI, K_CPI, K_ANDI, K_ORI: begin
            r.a = {1'b1, w[7:4]};
         end
         K_ADIW, K_SBIW: begin
            r.a = {2'b11, w[5:4], 1'b0};
            r.b = {2'b11, w[5:4], 1'b1};
         end
         K_MULS: begin
            r.a = {1'b1, w[7:4]};
            r.b = {1'b1, w[3:0]};
         end
         K_MULSU, K_FMUL, K_FMULS, K_FMULSU: begin
            r.a = {2'b10, w[6:4]};
            r.b = {2'b10, w[2:0]};
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

   function automatic logic [7:0] put_flags(input logic [7:0] old, input logic [7:0] keep,
                                            input logic c, input logic z, input logic n,
                                            input logic v, input logic h);
      logic [7:0] full;
      full = {2'b00, h, n ^ v, v, n, z, c};
      return (old & keep) | (full & ~keep);
   endfunction

   function automatic logic [7:0] flags_add(input logic [7:0] old, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] r);
      logic [7:0] cy;
      logic       v;
      cy = (a & b) | (~r & (a | b));
      v  = (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]);
      return put_flags(old, 8'hc0, cy[7], r == 8'h00, r[7], v, cy[3]);
   endfunction

   function automatic logic [7:0] flags_sub(input logic [7:0] old, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] r,
                                            input logic chain);
      logic [7:0] bw;
      logic       v;
      logic       z;
      bw = (~a & b) | (b & r) | (~a & r);
      v  = (a[7] & ~b[7] & ~r[7]) | (~a[7] & b[7] & r[7]);
      z  = (r == 8'h00) & (~chain | old[1]);
      return put_flags(old, 8'hc0, bw[7], z, r[7], v, bw[3]);
   endfunction

endpackage

`default_nettype wire

// File: sv/mcuaef_ram.sv
// ----------------------------------------------------------------------------
// mcuaef_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcuaef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// File: sv/mcuaef_exec.sv
// ----------------------------------------------------------------------------
// mcuaef_exec
// Combinational execute logic: results, flags, register writes and pc step.
// ----------------------------------------------------------------------------
`default_nettype none

module mcuaef_exec
   import mcuaef_pkg::*;
(
   input  wire logic [4:0]   kind,
   input  wire logic [15:0]  word,
   input  wire logic [7:0]   op_a,
   input  wire logic [7:0]   op_b,
   input  wire logic [7:0]   flags,
   output exec_res_type      res
);

   logic               cin;
   logic [7:0]         imm;
   logic [7:0]         r8;
   logic [15:0]        old16;
   logic [15:0]        res16;
   logic [15:0]        prod;
   logic signed [17:0] p18;
   logic               sa;
   logic               sb;
   logic               c;
   logic               v;
   logic               tk;

   always_comb begin
      cin   = flags[0];
      imm   = {word[11:8], word[3:0]};
      r8    = '0;
      old16 = {op_b, op_a};
      res16 = '0;
      sa    = 1'b0;
      sb    = 1'b0;
      c     = 1'b0;
      v     = 1'b0;
      tk    = 1'b0;
      p18   = '0;
      prod  = '0;
      res       = '0;
      res.flags = flags;
      res.delta = DELTA_BITS'(2);
      unique case (kind_type'(kind)) inside
         K_ADD, K_ADC: begin
            r8 = op_a + op_b + {7'b0, cin & (kind == K_ADC)};
            res.flags = flags_add(flags, op_a, op_b, r8);
            res.idx = word[8:4]; res.lo = r8; res.wl = 1'b1;
         end
         K_SUB, K_SBC, K_CP, K_CPC: begin
            r8 = op_a - op_b - {7'b0, cin & ((kind == K_SBC) | (kind == K_CPC))};
            res.flags = flags_sub(flags, op_a, op_b, r8, (kind == K_SBC) | (kind == K_CPC));
            if ((kind == K_SUB) || (kind == K_SBC)) begin
               res.idx = word[8:4]; res.lo = r8; res.wl = 1'b1;
            end
         end
         K_SUBI, K_SBCI, K_CPI: begin
            r8 = op_a - imm - {7'b0, cin & (kind == K_SBCI)};
            res.flags = flags_sub(flags, op_a, imm, r8, kind == K_SBCI);
            if (kind != K_CPI) begin
               res.idx = {1'b1, word[7:4]}; res.lo = r8; res.wl = 1'b1;
            end
         end
         K_ADIW, K_SBIW: begin
            if (kind == K_ADIW) begin
               res16 = old16 + {10'b0, word[7:6], word[3:0]};
               c = ~res16[15] & op_b[7];
               v = res16[15] & ~op_b[7];
            end else begin
               res16 = old16 - {10'b0, word[7:6], word[3:0]};
               c = res16[15] & ~op_b[7];
               v = ~res16[15] & op_b[7];
            end
            res.flags = put_flags(flags, 8'he0, c, res16 == 16'h0000, res16[15], v, 1'b0);
            res.idx = {2'b11, word[5:4], 1'b0};
            res.lo = res16[7:0]; res.hi = res16[15:8];
            res.wl = 1'b1; res.wh = 1'b1; res.lng = 1'b1;
         end
         K_AND, K_OR, K_EOR: begin
            r8 = (kind == K_AND) ? (op_a & op_b) : (kind == K_OR) ? (op_a | op_b)
                                                                  : (op_a ^ op_b);
            res.flags = put_flags(flags, 8'he1, 1'b0, r8 == 8'h00, r8[7], 1'b0, 1'b0);
            res.idx = word[8:4]; res.lo = r8; res.wl = 1'b1;
         end
         K_ANDI, K_ORI: begin
            r8 = (kind == K_ANDI) ? (op_a & imm) : (op_a | imm);
            res.flags = put_flags(flags, 8'he1, 1'b0, r8 == 8'h00, r8[7], 1'b0, 1'b0);
            res.idx = {1'b1, word[7:4]}; res.lo = r8; res.wl = 1'b1;
         end
         K_COM: begin
            r8 = ~op_a;
            res.flags = put_flags(flags, 8'he0, 1'b1, r8 == 8'h00, r8[7], 1'b0, 1'b0);
            res.idx = word[8:4]; res.lo = r8; res.wl = 1'b1;
         end
         K_NEG: begin
            r8 = 8'h00 - op_a;
            res.flags = flags_sub(flags, 8'h00, op_a, r8, 1'b0);
            res.idx = word[8:4]; res.lo = r8; res.wl = 1'b1;
         end
         K_INC, K_DEC: begin
            r8 = (kind == K_INC) ? (op_a + 8'd1) : (op_a - 8'd1);
            v  = (kind == K_INC) ? (r8 == 8'h80) : (r8 == 8'h7f);
            res.flags = put_flags(flags, 8'he1, 1'b0, r8 == 8'h00, r8[7], v, 1'b0);
            res.idx = word[8:4]; res.lo = r8; res.wl = 1'b1;
         end
         K_MUL, K_MULS, K_MULSU, K_FMUL, K_FMULS, K_FMULSU: begin
            sa   = (kind == K_MULS) | (kind == K_MULSU) | (kind == K_FMULS) | (kind == K_FMULSU);
            sb   = (kind == K_MULS) | (kind == K_FMULS);
            p18  = $signed({sa & op_a[7], op_a}) * $signed({sb & op_b[7], op_b});
            prod = p18[15:0];
            if ((kind == K_FMUL) || (kind == K_FMULS) || (kind == K_FMULSU)) begin
               res16 = {prod[14:0], 1'b0};
            end else begin
               res16 = prod;
            end
            res.flags = put_flags(flags, 8'hfc, prod[15], res16 == 16'h0000, 1'b0, 1'b0, 1'b0);
            res.idx = 5'd0; res.lo = res16[7:0]; res.hi = res16[15:8];
            res.wl = 1'b1; res.wh = 1'b1; res.lng = 1'b1;
         end
         K_LDI: begin
            res.idx = {1'b1, word[7:4]}; res.lo = imm; res.wl = 1'b1;
         end
         K_RJMP: begin
            res.delta = ({{2{word[11]}}, word[11:0]} + DELTA_BITS'(1)) << 1;
            res.taken = 1'b1; res.lng = 1'b1;
         end
         K_BRANCH: begin
            tk = flags[word[2:0]] ^ word[10];
            res.taken = tk;
            if (tk) begin
               res.delta = ({{7{word[9]}}, word[9:3]} + DELTA_BITS'(1)) << 1;
               res.lng   = 1'b1;
            end
         end
         default: begin
            res.delta = DELTA_BITS'(2);
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/mcu_alu_execute_with_flags_top.sv
// ----------------------------------------------------------------------------
// mcu_alu_execute_with_flags_top
// Executes one classified instruction per transfer against a register file,
// a status register and a program counter, and reports the outcome.
//
//  Channel | Direction | Payload
//  req_    | in        | kind, instr_word
//  rsp_    | out       | next_pc, status_flags, dest_index, dest_low, dest_high,
//          |           | write_low, write_high, branch_taken, long_instruction
//
// One instruction per cycle unless the result stalls; the register file read
// is registered, then the execution result is registered into the response.
// The register file sits in two banked RAM pairs with registered reads, and
// the write of the executing instruction is bypassed to the one being read.
// Reset clears the register valid bits, flags and pc; no clearing pass.
// A stalled result holds the execute stage, which in turn holds the request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mcu_alu_execute_with_flags_top_macros.svh"

module mcu_alu_execute_with_flags_top
   import mcuaef_pkg::*;
#(
   parameter int PC_BITS = PC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // kind[4:0], instr_word[20:5], zero[23:21]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [55:0] rsp_tdata   // next_pc[15:0], status_flags[23:16],
                                        // dest_index[28:24], dest_low[36:29],
                                        // dest_high[44:37], write_low[45],
                                        // write_high[46], branch_taken[47],
                                        // long_instruction[48], zero[55:49]
);

   localparam int BA = $clog2(BANK_DEPTH);

   logic                acc;
   rd_pair_type         rda;
   logic                s1_v_ff;
   logic                s1_fire;
   logic [4:0]          kind_ff;
   logic [15:0]         word_ff;
   logic                byp_a_ff, byp_b_ff, vld_a_ff, vld_b_ff, sel_a_ff, sel_b_ff;
   logic [7:0]          bypd_a_ff, bypd_b_ff;
   logic                byp_a_in, byp_b_in;
   logic [7:0]          bypd_a_in, bypd_b_in;
   logic [REG_COUNT-1:0] vld_ff;
   logic [7:0]          q_ae, q_ao, q_be, q_bo;
   logic [7:0]          op_a, op_b;
   logic [7:0]          flags_ff;
   logic [PC_BITS-1:0]  pc_ff, pc_in;
   exec_res_type        ex;
   logic                ev_we, od_we;
   logic [4:0]          ev_addr, od_addr, idx_p1;
   logic [7:0]          ev_data, od_data;
   logic                rsp_v_ff;
   logic [55:0]         rsp_d_ff;

   assign s1_fire    = s1_v_ff && (!rsp_v_ff || rsp_tready);
   assign req_tready = !s1_v_ff || s1_fire;
   assign acc        = req_tvalid && req_tready;
   assign rda        = rd_addr(req_tdata[4:0], req_tdata[20:5]);

   assign idx_p1 = ex.idx + 5'd1;
   always_comb begin
      ev_we = 1'b0; ev_addr = ex.idx; ev_data = ex.lo;
      od_we = 1'b0; od_addr = ex.idx; od_data = ex.lo;
      if (ex.wl && !ex.idx[0]) begin
         ev_we = s1_fire;
      end else if (ex.wh && ex.idx[0]) begin
         ev_we = s1_fire; ev_addr = idx_p1; ev_data = ex.hi;
      end
      if (ex.wl && ex.idx[0]) begin
         od_we = s1_fire;
      end else if (ex.wh && !ex.idx[0]) begin
         od_we = s1_fire; od_addr = idx_p1; od_data = ex.hi;
      end
   end

   always_comb begin
      byp_a_in  = 1'b0; bypd_a_in = ev_data;
      byp_b_in  = 1'b0; bypd_b_in = ev_data;
      if (ev_we && (ev_addr == rda.a)) begin
         byp_a_in = 1'b1;
      end else if (od_we && (od_addr == rda.a)) begin
         byp_a_in = 1'b1; bypd_a_in = od_data;
      end
      if (ev_we && (ev_addr == rda.b)) begin
         byp_b_in = 1'b1;
      end else if (od_we && (od_addr == rda.b)) begin
         byp_b_in = 1'b1; bypd_b_in = od_data;
      end
   end

   mcuaef_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_ae (
      .clock(clock), .we(ev_we), .waddr(ev_addr[4:1]), .wdata(ev_data),
      .re(acc), .raddr(rda.a[BA:1]), .rdata(q_ae));
   mcuaef_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_ao (
      .clock(clock), .we(od_we), .waddr(od_addr[4:1]), .wdata(od_data),
      .re(acc), .raddr(rda.a[BA:1]), .rdata(q_ao));
   mcuaef_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_be (
      .clock(clock), .we(ev_we), .waddr(ev_addr[4:1]), .wdata(ev_data),
      .re(acc), .raddr(rda.b[BA:1]), .rdata(q_be));
   mcuaef_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_bo (
      .clock(clock), .we(od_we), .waddr(od_addr[4:1]), .wdata(od_data),
      .re(acc), .raddr(rda.b[BA:1]), .rdata(q_bo));

   always_ff @(posedge clock) begin
      if (acc) begin
         kind_ff   <= req_tdata[4:0];
         word_ff   <= req_tdata[20:5];
         byp_a_ff  <= byp_a_in;
         byp_b_ff  <= byp_b_in;
         bypd_a_ff <= bypd_a_in;
         bypd_b_ff <= bypd_b_in;
         vld_a_ff  <= vld_ff[rda.a];
         vld_b_ff  <= vld_ff[rda.b];
         sel_a_ff  <= rda.a[0];
         sel_b_ff  <= rda.b[0];
      end
   end

   assign op_a = byp_a_ff ? bypd_a_ff : (vld_a_ff ? (sel_a_ff ? q_ao : q_ae) : 8'h00);
   assign op_b = byp_b_ff ? bypd_b_ff : (vld_b_ff ? (sel_b_ff ? q_bo : q_be) : 8'h00);

   mcuaef_exec u_exec (
      .kind(kind_ff), .word(word_ff), .op_a(op_a), .op_b(op_b),
      .flags(flags_ff), .res(ex));

   assign pc_in = pc_ff + PC_BITS'($signed(ex.delta));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         vld_ff   <= '0;
         flags_ff <= '0;
         pc_ff    <= '0;
      end else begin
         if (acc) begin
            s1_v_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
         if (ev_we) begin
            vld_ff[ev_addr] <= 1'b1;
         end
         if (od_we) begin
            vld_ff[od_addr] <= 1'b1;
         end
         if (s1_fire) begin
            flags_ff <= ex.flags;
            pc_ff    <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_d_ff <= {7'b0, ex.lng, ex.taken, ex.wh, ex.wl,
                      ex.wh ? ex.hi : 8'h00,
                      ex.wl ? ex.lo : 8'h00,
                      ex.wl ? ex.idx : 5'd0,
                      ex.flags, 16'(pc_in)};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   `MCUAEF_ASSERT_NEXT(a_fire_gives_result, clock, reset, s1_fire, rsp_tvalid)
   `MCUAEF_ASSERT_NEXT(a_stall_holds_stage, clock, reset, s1_v_ff && !s1_fire, s1_v_ff)
   `MCUAEF_ASSERT_SAME(a_pair_even, clock, reset, s1_v_ff && ex.wh, ex.wl && !ex.idx[0])
   `MCUAEF_ASSERT_SAME(a_one_bank_write, clock, reset, ev_we && od_we, ex.wl && ex.wh)

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ALU execute block. A directed run, then random
// bursts are sent; results are checked field by field against a behavioural
// model of the register file, status register and program counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import mcuaef_pkg::*;
;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  flags;
      logic [4:0]  idx;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic        wl;
      logic        wh;
      logic        taken;
      logic        lng;
   } outcome_t;

   class exec_scoreboard;
      logic [7:0]  regs[32];
      logic [7:0]  sreg;
      logic [15:0] pc;
      outcome_t    pending[$];
      int          errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         sreg = '0;
         pc = '0;
         errors = 0;
      endfunction

      function void set_flags(logic [7:0] keep, logic c, logic z, logic n, logic v, logic h);
         logic [7:0] full;
         full = {2'b00, h, n ^ v, v, n, z, c};
         sreg = (sreg & keep) | (full & ~keep);
      endfunction

      function void add_flags(logic [7:0] a, logic [7:0] b, logic [7:0] r);
         logic [7:0] cy;
         cy = (a & b) | (~r & (a | b));
         set_flags(8'hc0, cy[7], r == 0, r[7],
                   (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]), cy[3]);
      endfunction

      function void sub_flags(logic [7:0] a, logic [7:0] b, logic [7:0] r, logic chain);
         logic [7:0] bw;
         logic       z;
         bw = (~a & b) | (b & r) | (~a & r);
         z = (r == 0) & (~chain | sreg[1]);
         set_flags(8'hc0, bw[7], z, r[7],
                   (a[7] & ~b[7] & ~r[7]) | (~a[7] & b[7] & r[7]), bw[3]);
      endfunction

      function void note_instruction(kind_type k, logic [15:0] w);
         outcome_t    o;
         logic [4:0]  rd, rr, hd, x, y, p;
         logic [7:0]  imm, a, b, r, vh;
         logic [5:0]  kw;
         logic [15:0] old, res, prod, delta;
         logic        cin, c, v, chain;
         int          sp;
         rd = w[8:4];
         rr = {w[9], w[3:0]};
         hd = {1'b1, w[7:4]};
         imm = {w[11:8], w[3:0]};
         cin = sreg[0];
         delta = 16'd2;
         o = '0;
         case (k)
            K_ADD, K_ADC: begin
               a = regs[rd]; b = regs[rr];
               r = a + b + ((k == K_ADC) ? cin : 1'b0);
               add_flags(a, b, r);
               o.idx = rd; o.lo = r; o.wl = 1;
            end
            K_SUB, K_SBC, K_CP, K_CPC: begin
               chain = (k == K_SBC) || (k == K_CPC);
               a = regs[rd]; b = regs[rr];
               r = a - b - (chain ? cin : 1'b0);
               sub_flags(a, b, r, chain);
               if (k == K_SUB || k == K_SBC) begin
                  o.idx = rd; o.lo = r; o.wl = 1;
               end
            end
            K_SUBI, K_SBCI, K_CPI: begin
               a = regs[hd];
               r = a - imm - ((k == K_SBCI) ? cin : 1'b0);
               sub_flags(a, imm, r, k == K_SBCI);
               if (k != K_CPI) begin
                  o.idx = hd; o.lo = r; o.wl = 1;
               end
            end
            K_ADIW, K_SBIW: begin
               p = {2'b11, w[5:4], 1'b0};
               kw = {w[7:6], w[3:0]};
               vh = regs[p + 1];
               old = {vh, regs[p]};
               res = (k == K_ADIW) ? old + kw : old - kw;
               if (k == K_ADIW) begin
                  c = ~res[15] & vh[7]; v = res[15] & ~vh[7];
               end else begin
                  c = res[15] & ~vh[7]; v = ~res[15] & vh[7];
               end
               set_flags(8'he0, c, res == 0, res[15], v, 1'b0);
               o.idx = p; o.lo = res[7:0]; o.hi = res[15:8];
               o.wl = 1; o.wh = 1; o.lng = 1;
            end
            K_AND, K_OR, K_EOR, K_ANDI, K_ORI: begin
               if (k == K_ANDI || k == K_ORI) begin
                  a = regs[hd]; b = imm; o.idx = hd;
               end else begin
                  a = regs[rd]; b = regs[rr]; o.idx = rd;
               end
               r = (k == K_AND || k == K_ANDI) ? (a & b) :
                   (k == K_EOR) ? (a ^ b) : (a | b);
               set_flags(8'he1, 1'b0, r == 0, r[7], 1'b0, 1'b0);
               o.lo = r; o.wl = 1;
            end
            K_COM: begin
               r = ~regs[rd];
               set_flags(8'he0, 1'b1, r == 0, r[7], 1'b0, 1'b0);
               o.idx = rd; o.lo = r; o.wl = 1;
            end
            K_NEG: begin
               a = regs[rd];
               r = 8'd0 - a;
               sub_flags(8'd0, a, r, 1'b0);
               o.idx = rd; o.lo = r; o.wl = 1;
            end
            K_INC, K_DEC: begin
               r = (k == K_INC) ? regs[rd] + 8'd1 : regs[rd] - 8'd1;
               set_flags(8'he1, 1'b0, r == 0, r[7],
                         (k == K_INC) ? (r == 8'h80) : (r == 8'h7f), 1'b0);
               o.idx = rd; o.lo = r; o.wl = 1;
            end
            K_MUL, K_MULS, K_MULSU, K_FMUL, K_FMULS, K_FMULSU: begin
               if (k == K_MUL) begin
                  x = rd; y = rr;
               end else if (k == K_MULS) begin
                  x = hd; y = {1'b1, w[3:0]};
               end else begin
                  x = {2'b10, w[6:4]}; y = {2'b10, w[2:0]};
               end
               a = regs[x]; b = regs[y];
               if (k == K_MUL || k == K_FMUL) sp = int'(a) * int'(b);
               else if (k == K_MULS || k == K_FMULS)
                  sp = int'($signed(a)) * int'($signed(b));
               else sp = int'($signed(a)) * int'(b);
               prod = sp[15:0];
               res = (k == K_MUL || k == K_MULS || k == K_MULSU) ? prod : {prod[14:0], 1'b0};
               set_flags(8'hfc, prod[15], res == 0, 1'b0, 1'b0, 1'b0);
               o.idx = 0; o.lo = res[7:0]; o.hi = res[15:8];
               o.wl = 1; o.wh = 1; o.lng = 1;
            end
            K_LDI: begin
               o.idx = hd; o.lo = imm; o.wl = 1;
            end
            K_RJMP: begin
               delta = {{3{w[11]}}, w[11:0], 1'b0} + 16'd2;
               o.taken = 1; o.lng = 1;
            end
            K_BRANCH: begin
               o.taken = sreg[w[2:0]] ^ w[10];
               if (o.taken) begin
                  delta = {{8{w[9]}}, w[9:3], 1'b0} + 16'd2;
                  o.lng = 1;
               end
            end
            default: ;
         endcase
         if (o.wl) regs[o.idx] = o.lo;
         if (o.wh) regs[o.idx + 5'd1] = o.hi;
         pc = pc + delta;
         o.pc = pc;
         o.flags = sreg;
         pending.push_back(o);
      endfunction

      function void check_result(logic [55:0] d);
         outcome_t e, g;
         g = '{d[15:0], d[23:16], d[28:24], d[36:29], d[44:37], d[45], d[46], d[47], d[48]};
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.pc != g.pc) report("next_pc", e.pc, g.pc);
         if (e.flags != g.flags) report("status_flags", 16'(e.flags), 16'(g.flags));
         if (e.idx != g.idx) report("dest_index", 16'(e.idx), 16'(g.idx));
         if (e.lo != g.lo) report("dest_low", 16'(e.lo), 16'(g.lo));
         if (e.hi != g.hi) report("dest_high", 16'(e.hi), 16'(g.hi));
         if (e.wl != g.wl) report("write_low", 16'(e.wl), 16'(g.wl));
         if (e.wh != g.wh) report("write_high", 16'(e.wh), 16'(g.wh));
         if (e.taken != g.taken) report("branch_taken", 16'(e.taken), 16'(g.taken));
         if (e.lng != g.lng) report("long_instruction", 16'(e.lng), 16'(g.lng));
      endfunction

      function void report(string f, logic [15:0] e, logic [15:0] g);
         $display("%0t: %s expected %h actual %h", $time, f, e, g);
         errors++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;

   exec_scoreboard sb = new();
   logic        sending_done = 0;
   int          idle_cycles = 0;

   mcu_alu_execute_with_flags_top dut (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_instruction(kind_type'(req_tdata[4:0]), req_tdata[20:5]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_instruction(input logic [4:0] k, input logic [15:0] w);
      req_tdata <= {3'b000, w, k};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   function automatic logic [4:0] random_kind();
      int s;
      s = $urandom_range(0, 99);
      if (s < 6) return K_LDI;
      if (s < 9) return 5'(K_OTHER + $urandom_range(0, 2));
      return 5'($urandom_range(0, 28));
   endfunction

   initial begin
      logic [4:0] k;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_instruction(K_LDI, 16'hefff);
      send_instruction(K_LDI, 16'he000);
      send_instruction(K_LDI, 16'he7f1);
      send_instruction(K_ADD, 16'h0c01);
      send_instruction(K_ADC, 16'h1c00);
      send_instruction(K_SUB, 16'h1801);
      send_instruction(K_SBC, 16'h0800);
      send_instruction(K_CPC, 16'h0400);
      send_instruction(K_ADIW, 16'h96ff);
      send_instruction(K_SBIW, 16'h97ff);
      send_instruction(K_COM, 16'h9400);
      send_instruction(K_NEG, 16'h9410);
      send_instruction(K_INC, 16'h9423);
      send_instruction(K_DEC, 16'h940a);
      for (int i = K_MUL; i <= K_FMULS; i++) send_instruction(5'(i), 16'hffff);
      send_instruction(K_FMULSU, 16'h0377);
      send_instruction(K_RJMP, 16'hc800);
      send_instruction(K_RJMP, 16'hc7ff);
      send_instruction(K_BRANCH, 16'hf200);
      send_instruction(K_BRANCH, 16'hf5ff);
      send_instruction(5'd31, 16'h0000);
      for (int n = 0; n < 1100; n++) begin
         if ($urandom_range(0, 9) == 0) pause_sender();
         k = random_kind();
         send_instruction(k, 16'($urandom));
      end
      req_tvalid <= 0;
      sending_done <= 1;
   end

   initial begin
      int gap;
      gap = 0;
      rsp_tready <= 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (60) @(negedge clock);
      forever begin
         if (gap > 0) begin
            rsp_tready <= 0;
            gap--;
         end else begin
            rsp_tready <= 1;
            if ($urandom_range(0, 15) == 0) gap = $urandom_range(1, 5);
         end
         @(negedge clock);
      end
   end

   initial begin
      wait (sending_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
